// ----- src/akrt_pkg.sv -----
// Shared types and codes for the analog key rapid trigger block.
// Used by the controller, the datapath and the top level; no dependencies.
package akrt_pkg;

	localparam int MODE_W    = 2;
	localparam int CAL_W     = 2;
	localparam int THR_W     = 11;
	localparam int DZ_W      = 10;
	localparam int REG_IDX_W = 3;

	localparam logic [MODE_W-1:0] MODE_DIGITAL = 2'd0;
	localparam logic [MODE_W-1:0] MODE_THRESH  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RAPID   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_SPEED   = 2'd3;

	localparam logic [CAL_W-1:0] CAL_NONE     = 2'd0;
	localparam logic [CAL_W-1:0] CAL_POS      = 2'd1;
	localparam logic [CAL_W-1:0] CAL_NEG      = 2'd2;
	localparam logic [CAL_W-1:0] CAL_RESERVED = 2'd3;

	localparam logic [REG_IDX_W-1:0] REG_KEY_MODE   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_START_CAL  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_REST_LEVEL = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_EST_RANGE  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_PRESS_THR  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_RELEASE_THR = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_TOP_DZ     = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_BOTTOM_DZ  = 3'd7;

	localparam logic [MODE_W-1:0] MODE_RESET       = MODE_THRESH;
	localparam logic [CAL_W-1:0]  START_CAL_RESET  = CAL_NONE;
	localparam logic [THR_W-1:0]  PRESS_THR_RESET  = 11'sd200;
	localparam logic [THR_W-1:0]  RELEASE_THR_RESET = 11'sd150;
	localparam logic [DZ_W-1:0]   TOP_DZ_RESET     = 10'd20;
	localparam logic [DZ_W-1:0]   BOTTOM_DZ_RESET  = 10'd20;

	typedef struct packed {
		logic load;
		logic cal;
		logic prep;
		logic mul;
		logic div;
		logic commit;
	} cmd_t;

endpackage

// ----- src/analog_key_rapid_trigger.sv -----
// Top level of the analog key rapid trigger block.
// Instantiates akrt_ctrl and akrt_datapath; depends on akrt_pkg.
//
// Usage:
//   Input channel (in_valid, in_stall, raw_sample) takes one converter sample
//   per item. Output channel (out_valid, out_stall, key_pressed, position,
//   calibration) returns one result per sample, in order.
//   Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
//   one register per handshake; cfg_ready is always high. Writing the start
//   calibration, rest level or estimated range reloads the calibration state.
//   The serial divider produces one quotient bit per cycle. A new sample is
//   taken only after the last one has been committed to the output register;
//   in_stall is high while an item is in work.
//   A finished result waits in the output register while out_stall is high;
//   the next item is accepted meanwhile and holds in its last step until the
//   output register frees.
//   Reset: registers take their listed reset values, calibration starts from
//   the start calibration value, the key is released, no result is pending.
module analog_key_rapid_trigger #(
	parameter int RAW_BITS  = 12,
	parameter int VALUE_MAX = 1023
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic [RAW_BITS-1:0]                      raw_sample,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic                                     key_pressed,
	output logic [$clog2(VALUE_MAX+1)-1:0]           position,
	output logic [akrt_pkg::CAL_W-1:0]               calibration,
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [akrt_pkg::REG_IDX_W-1:0]           cfg_index,
	input  logic [((RAW_BITS > 11) ? RAW_BITS : 11)-1:0] cfg_data
);
	import akrt_pkg::*;

	cmd_t cmd;

	assign cfg_ready = 1'b1;

	akrt_ctrl #(
		.VALUE_MAX(VALUE_MAX)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd)
	);

	akrt_datapath #(
		.RAW_BITS (RAW_BITS),
		.VALUE_MAX(VALUE_MAX)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.raw_sample (raw_sample),
		.key_pressed(key_pressed),
		.position   (position),
		.calibration(calibration)
	);

endmodule

// ----- src/akrt_ctrl.sv -----
// Sequencer for the analog key rapid trigger block: input and output handshakes,
// step order and divider step count. Depends on akrt_pkg.
module akrt_ctrl #(
	parameter int VALUE_MAX = 1023
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	output akrt_pkg::cmd_t cmd
);
	import akrt_pkg::*;

	localparam int VB = $clog2(VALUE_MAX + 1);
	localparam int CW = $clog2(VB);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CAL  = 3'd1;
	localparam logic [2:0] S_PREP = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          out_valid_q;
	logic          accept;
	logic          can_commit;

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign accept     = in_valid && !in_stall;
	assign can_commit = !out_valid_q || !out_stall;

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		cmd        = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CAL;
				end
			end
			S_CAL: begin
				cmd.cal = 1'b1;
				state_d = S_PREP;
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				cnt_d   = CW'(VB - 1);
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div = 1'b1;
				if (cnt_q == '0) begin
					state_d = S_DONE;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			S_DONE: begin
				if (can_commit) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_CAL)
		else $error("accepted item did not start calibration step");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("committed item not shown on output");

	a_hold_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && out_stall) |=> state_q == S_DONE)
		else $error("finished item overwrote a waiting result");

endmodule

// ----- src/akrt_datapath.sv -----
// Datapath of the analog key rapid trigger block: configuration registers,
// calibration tracking, normalization with a serial divider and mode logic.
// Depends on akrt_pkg.
module akrt_datapath #(
	parameter int RAW_BITS  = 12,
	parameter int VALUE_MAX = 1023
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  akrt_pkg::cmd_t                           cmd,
	input  logic                                     cfg_we,
	input  logic [akrt_pkg::REG_IDX_W-1:0]           cfg_index,
	input  logic [((RAW_BITS > 11) ? RAW_BITS : 11)-1:0] cfg_data,
	input  logic [RAW_BITS-1:0]                      raw_sample,
	output logic                                     key_pressed,
	output logic [$clog2(VALUE_MAX+1)-1:0]           position,
	output logic [akrt_pkg::CAL_W-1:0]               calibration
);
	import akrt_pkg::*;

	localparam int RB = RAW_BITS;
	localparam int VB = $clog2(VALUE_MAX + 1);
	localparam int FW = RB + 2;
	localparam int SW = RB + 3;
	localparam int NW = RB + 2;
	localparam int PW = NW + VB;
	localparam int MW = (VB + 2 > 12) ? VB + 2 : 12;
	localparam logic [VB-1:0] VM_C = VB'(VALUE_MAX);
	localparam logic [RB-1:0] REST_RESET = RB'(1 << (RB - 1));
	localparam logic [RB-1:0] RANGE_RESET = (RB > 8) ? RB'(300) : RB'(1 << (RB - 2));

	logic [MODE_W-1:0]       mode_q;
	logic [CAL_W-1:0]        start_cal_q;
	logic [RB-1:0]           rest_q;
	logic [RB-1:0]           range_q;
	logic signed [THR_W-1:0] press_q;
	logic signed [THR_W-1:0] rel_q;
	logic [DZ_W-1:0]         tdz_q;
	logic [DZ_W-1:0]         bdz_q;

	logic [CAL_W-1:0]        sc_nx;
	logic [RB-1:0]           rest_nx;
	logic [RB-1:0]           range_nx;
	logic                    reload;
	logic [CAL_W-1:0]        rl_dir;
	logic signed [SW-1:0]    rl_far;

	logic [CAL_W-1:0]        dir_q;
	logic signed [FW-1:0]    far_q;
	logic [RB-1:0]           raw_q;
	logic                    locked_q;

	logic signed [SW-1:0]    rawx, restx, rangex, farx;
	logic [CAL_W-1:0]        cal_dir;
	logic signed [FW-1:0]    cal_far;
	logic                    cal_locked;

	logic signed [SW-1:0]    num_s, den_s, num_a, den_a;
	logic [NW-1:0]           num_q, den_q;
	logic                    zero_q, sat_q;

	logic [PW-1:0]           prod;
	logic [NW-1:0]           rem_q;
	logic [VB-1:0]           sh_q, quo_q;
	logic [NW:0]             trial;
	logic                    trial_ge;

	logic                    pressed_q;
	logic [VB-1:0]           last_q, ext_q;
	logic [VB-1:0]           pos;
	logic                    st;
	logic [VB-1:0]           last_d, ext_d;

	logic                    key_pressed_q;
	logic [VB-1:0]           position_q;
	logic [CAL_W-1:0]        calibration_q;

	assign sc_nx    = (cfg_we && cfg_index == REG_START_CAL) ? cfg_data[CAL_W-1:0] : start_cal_q;
	assign rest_nx  = (cfg_we && cfg_index == REG_REST_LEVEL) ? cfg_data[RB-1:0] : rest_q;
	assign range_nx = (cfg_we && cfg_index == REG_EST_RANGE) ? cfg_data[RB-1:0] : range_q;
	assign reload   = cfg_we && (cfg_index == REG_START_CAL || cfg_index == REG_REST_LEVEL ||
		cfg_index == REG_EST_RANGE);
	assign rl_dir   = (sc_nx == CAL_RESERVED) ? CAL_NONE : sc_nx;
	assign rl_far   = (rl_dir == CAL_POS)
		? $signed({3'b000, rest_nx}) + $signed({3'b000, range_nx})
		: $signed({3'b000, rest_nx}) - $signed({3'b000, range_nx});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_RESET;
			start_cal_q <= START_CAL_RESET;
			rest_q      <= REST_RESET;
			range_q     <= RANGE_RESET;
			press_q     <= PRESS_THR_RESET;
			rel_q       <= RELEASE_THR_RESET;
			tdz_q       <= TOP_DZ_RESET;
			bdz_q       <= BOTTOM_DZ_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_MODE:    mode_q      <= cfg_data[MODE_W-1:0];
				REG_START_CAL:   start_cal_q <= cfg_data[CAL_W-1:0];
				REG_REST_LEVEL:  rest_q      <= cfg_data[RB-1:0];
				REG_EST_RANGE:   range_q     <= cfg_data[RB-1:0];
				REG_PRESS_THR:   press_q     <= cfg_data[THR_W-1:0];
				REG_RELEASE_THR: rel_q       <= cfg_data[THR_W-1:0];
				REG_TOP_DZ:      tdz_q       <= cfg_data[DZ_W-1:0];
				REG_BOTTOM_DZ:   bdz_q       <= cfg_data[DZ_W-1:0];
				default: ;
			endcase
		end
	end

	assign rawx   = $signed({3'b000, raw_q});
	assign restx  = $signed({3'b000, rest_q});
	assign rangex = $signed({3'b000, range_q});
	assign farx   = {far_q[FW-1], far_q};

	always_comb begin
		cal_dir    = dir_q;
		cal_far    = far_q;
		cal_locked = 1'b1;
		priority if (dir_q == CAL_POS) begin
			if (rawx > farx) cal_far = FW'(rawx);
		end else if (dir_q == CAL_NEG) begin
			if (rawx < farx) cal_far = FW'(rawx);
		end else if (rawx - restx > rangex) begin
			cal_dir = CAL_POS;
			cal_far = FW'(rawx);
		end else if (restx - rawx > rangex) begin
			cal_dir = CAL_NEG;
			cal_far = FW'(rawx);
		end else begin
			cal_locked = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q    <= CAL_NONE;
			far_q    <= FW'($signed({3'b000, REST_RESET}) - $signed({3'b000, RANGE_RESET}));
			locked_q <= 1'b0;
		end else if (reload) begin
			dir_q <= rl_dir;
			far_q <= FW'(rl_far);
		end else if (cmd.cal) begin
			dir_q    <= cal_dir;
			far_q    <= cal_far;
			locked_q <= cal_locked;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) raw_q <= raw_sample;
	end

	assign num_s = restx - rawx;
	assign den_s = restx - farx;
	assign num_a = den_s[SW-1] ? -num_s : num_s;
	assign den_a = den_s[SW-1] ? -den_s : den_s;

	assign prod     = {{VB{1'b0}}, num_q} * {{NW{1'b0}}, VM_C};
	assign trial    = {rem_q, sh_q[VB-1]};
	assign trial_ge = trial >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			num_q  <= num_a[NW-1:0];
			den_q  <= den_a[NW-1:0];
			zero_q <= !locked_q || den_s == '0 || num_a <= 0;
			sat_q  <= num_a >= den_a;
		end
		if (cmd.mul) begin
			rem_q <= prod[PW-1:VB];
			sh_q  <= prod[VB-1:0];
			quo_q <= '0;
		end else if (cmd.div) begin
			rem_q <= trial_ge ? NW'(trial - {1'b0, den_q}) : trial[NW-1:0];
			sh_q  <= {sh_q[VB-2:0], 1'b0};
			quo_q <= {quo_q[VB-2:0], trial_ge};
		end
	end

	assign pos = zero_q ? '0 : (sat_q ? VM_C : quo_q);

	always_comb begin
		logic signed [MW-1:0] v, lastx, extx, pthr, rthr, tdzx, bdzx, vmx, d;
		v     = $signed({{(MW-VB){1'b0}}, pos});
		lastx = $signed({{(MW-VB){1'b0}}, last_q});
		extx  = $signed({{(MW-VB){1'b0}}, ext_q});
		pthr  = {{(MW-THR_W){press_q[THR_W-1]}}, press_q};
		rthr  = {{(MW-THR_W){rel_q[THR_W-1]}}, rel_q};
		tdzx  = $signed({{(MW-DZ_W){1'b0}}, tdz_q});
		bdzx  = $signed({{(MW-DZ_W){1'b0}}, bdz_q});
		vmx   = $signed({{(MW-VB){1'b0}}, VM_C});
		d     = v - lastx;
		st     = pressed_q;
		last_d = last_q;
		ext_d  = ext_q;
		unique case (mode_q)
			MODE_DIGITAL: begin
				st = locked_q && raw_q != '0;
			end
			MODE_THRESH: begin
				last_d = pos;
				if (v > pthr) st = 1'b1;
				if (v < rthr) st = 1'b0;
			end
			MODE_RAPID: begin
				last_d = pos;
				priority if (v <= tdzx) begin
					st    = 1'b0;
					ext_d = pos;
				end else if (v >= vmx - bdzx) begin
					st    = 1'b1;
					ext_d = pos;
				end else begin
					if (pressed_q && extx - v >= rthr) begin
						st    = 1'b0;
						ext_d = pos;
					end
					if (!pressed_q && v - extx >= pthr) begin
						st    = 1'b1;
						ext_d = pos;
					end
					if ((pressed_q && v > extx) || (!pressed_q && v < extx)) ext_d = pos;
				end
			end
			MODE_SPEED: begin
				last_d = pos;
				if (d > pthr) st = 1'b1;
				if (d < rthr) st = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q <= 1'b0;
			last_q    <= '0;
			ext_q     <= '0;
		end else if (cmd.commit) begin
			pressed_q <= st;
			last_q    <= last_d;
			ext_q     <= ext_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			key_pressed_q <= st;
			position_q    <= pos;
			calibration_q <= dir_q;
		end
	end

	assign key_pressed = key_pressed_q;
	assign position    = position_q;
	assign calibration = calibration_q;

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div && !zero_q && !sat_q) |-> rem_q < den_q)
		else $error("divider remainder not below divisor");

	a_lock_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.cal && dir_q != CAL_NONE && !reload) |=> locked_q && dir_q == $past(dir_q))
		else $error("locked calibration changed during an item");

endmodule

// ----- bench/analog_key_rapid_trigger_tb.sv -----
// Self-checking bench for analog_key_rapid_trigger: feeds converter samples, predicts
// pressed state, travel and calibration per sample, and checks every result in order.
// Depends on akrt_pkg and the analog_key_rapid_trigger RTL only.
module analog_key_rapid_trigger_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import akrt_pkg::*;

	localparam int RAW_BITS    = 12;
	localparam int VALUE_MAX   = 1023;
	localparam int DRAIN_MARK  = -1;
	localparam int SETTLE_GAP  = 20;
	localparam int QUIET_LIMIT = 3000;

	typedef struct packed {
		logic       pressed;
		logic [9:0] position;
		logic [1:0] calibration;
	} key_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [11:0] raw_sample = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        key_pressed;
	logic [9:0]  position;
	logic [1:0]  calibration;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [11:0] cfg_data = '0;

	// register copies
	logic [1:0] mode_reg;
	logic [1:0] start_cal;
	int         rest_lvl;
	int         span;
	int         press_thr;
	int         release_thr;
	int         top_dz;
	int         bottom_dz;

	// key state
	bit         pressed_st;
	int         last_pos;
	int         extremum;
	int         far_bound;
	logic [1:0] cal_dir;

	int          sample_q[$];
	key_result_t result_q[$];
	key_result_t want;
	bit          in_taken;
	int          send_idle;
	int          recv_idle;
	int          n_samples;
	int          n_results;
	int          n_writes;
	int          n_settings;
	int          fails;
	int          quiet;

	analog_key_rapid_trigger #(
		.RAW_BITS (RAW_BITS),
		.VALUE_MAX(VALUE_MAX)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.raw_sample (raw_sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.key_pressed(key_pressed),
		.position   (position),
		.calibration(calibration),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void rearm_calibration();
		cal_dir = (start_cal == CAL_RESERVED) ? CAL_NONE : start_cal;
		far_bound = (cal_dir == CAL_POS) ? rest_lvl + span : rest_lvl - span;
	endfunction

	function automatic void reset_key_model();
		mode_reg = MODE_RESET;
		start_cal = START_CAL_RESET;
		rest_lvl = 2048;
		span = 300;
		press_thr = int'($signed(PRESS_THR_RESET));
		release_thr = int'($signed(RELEASE_THR_RESET));
		top_dz = int'(TOP_DZ_RESET);
		bottom_dz = int'(BOTTOM_DZ_RESET);
		pressed_st = 1'b0;
		last_pos = 0;
		extremum = 0;
		rearm_calibration();
	endfunction

	function automatic void apply_reg(input logic [2:0] idx, input logic [11:0] data);
		case (idx)
		REG_KEY_MODE: mode_reg = data[1:0];
		REG_START_CAL: begin
			start_cal = data[1:0];
			rearm_calibration();
		end
		REG_REST_LEVEL: begin
			rest_lvl = int'(data);
			rearm_calibration();
		end
		REG_EST_RANGE: begin
			span = int'(data);
			rearm_calibration();
		end
		REG_PRESS_THR: press_thr = int'($signed(data[10:0]));
		REG_RELEASE_THR: release_thr = int'($signed(data[10:0]));
		REG_TOP_DZ: top_dz = int'(data[9:0]);
		default: bottom_dz = int'(data[9:0]);
		endcase
	endfunction

	function automatic int travel_of(input int raw);
		longint num;
		longint den;
		longint q;
		num = rest_lvl - raw;
		den = rest_lvl - far_bound;
		if (den == 0)
			return 0;
		if (den < 0) begin
			den = -den;
			num = -num;
		end
		if (num <= 0)
			return 0;
		q = num * VALUE_MAX / den;
		return (q > VALUE_MAX) ? VALUE_MAX : int'(q);
	endfunction

	function automatic void update_press(input int v);
		bit was;
		bit now;
		int d;
		was = pressed_st;
		now = was;
		case (mode_reg)
		MODE_DIGITAL: now = (v != 0);
		MODE_THRESH: begin
			last_pos = v;
			if (v > press_thr)
				now = 1'b1;
			if (v < release_thr)
				now = 1'b0;
		end
		MODE_RAPID: begin
			last_pos = v;
			if (v <= top_dz) begin
				now = 1'b0;
				extremum = v;
			end else if (v >= VALUE_MAX - bottom_dz) begin
				now = 1'b1;
				extremum = v;
			end else begin
				if (was && extremum - v >= release_thr) begin
					now = 1'b0;
					extremum = v;
				end
				if (!was && v - extremum >= press_thr) begin
					now = 1'b1;
					extremum = v;
				end
				if ((was && v > extremum) || (!was && v < extremum))
					extremum = v;
			end
		end
		default: begin
			d = v - last_pos;
			if (d > press_thr)
				now = 1'b1;
			if (d < release_thr)
				now = 1'b0;
			last_pos = v;
		end
		endcase
		pressed_st = now;
	endfunction

	function automatic key_result_t sense_key(input int raw);
		key_result_t r;
		bit locked;
		int pos;
		locked = 1'b1;
		pos = 0;
		if (cal_dir == CAL_POS) begin
			if (raw > far_bound)
				far_bound = raw;
		end else if (cal_dir == CAL_NEG) begin
			if (raw < far_bound)
				far_bound = raw;
		end else if (raw - rest_lvl > span) begin
			cal_dir = CAL_POS;
			far_bound = raw;
		end else if (rest_lvl - raw > span) begin
			cal_dir = CAL_NEG;
			far_bound = raw;
		end else begin
			locked = 1'b0;
		end
		if (locked)
			pos = travel_of(raw);
		update_press(!locked ? 0 : (mode_reg == MODE_DIGITAL ? raw : pos));
		r.pressed = pressed_st;
		r.position = pos[9:0];
		r.calibration = cal_dir;
		return r;
	endfunction

	function automatic int push_stroke(input int rest, input int depth_max, input bit up);
		int depth;
		int steps;
		int s;
		int k;
		depth = $urandom_range(depth_max + depth_max / 2 + 16);
		steps = $urandom_range(2, 8);
		for (k = 0; k <= 2 * steps; k++) begin
			s = depth * (k <= steps ? k : 2 * steps - k) / steps + $urandom_range(8) - 4;
			s = up ? rest + s : rest - s;
			sample_q.push_back(s < 0 ? 0 : (s > 4095 ? 4095 : s));
		end
		return 2 * steps + 1;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_setting(input int mode, input int start, input int rest, input int rng,
			input int press, input int rel, input int tdz, input int bdz);
		logic [11:0] junk;
		junk = 12'($urandom);
		write_reg(REG_KEY_MODE, {junk[11:2], mode[1:0]});
		write_reg(REG_START_CAL, {junk[9:0], start[1:0]});
		write_reg(REG_REST_LEVEL, rest[11:0]);
		write_reg(REG_EST_RANGE, rng[11:0]);
		write_reg(REG_PRESS_THR, {junk[11], press[10:0]});
		write_reg(REG_RELEASE_THR, {junk[10], rel[10:0]});
		write_reg(REG_TOP_DZ, {junk[5:4], tdz[9:0]});
		write_reg(REG_BOTTOM_DZ, {junk[3:2], bdz[9:0]});
		@(negedge clk);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	task automatic settle();
		while (sample_q.size() != 0 || in_valid || result_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_GAP) @(posedge clk);
	endtask

	// item source; a drain mark holds the next item until every result is back
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (sample_q.size() != 0 && sample_q[0] == DRAIN_MARK) begin
				if (result_q.size() == 0)
					void'(sample_q.pop_front());
				in_valid <= 1'b0;
			end else if (sample_q.size() != 0 && $urandom_range(99) >= send_idle) begin
				in_valid <= 1'b1;
				raw_sample <= 12'(sample_q.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			in_taken = in_valid && !in_stall;
			if (cfg_valid && cfg_ready) begin
				apply_reg(cfg_index, cfg_data);
				n_writes++;
			end
			if (in_taken) begin
				result_q.push_back(sense_key(int'(raw_sample)));
				n_samples++;
			end
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					$error("unexpected result: key_pressed %0d position %0d calibration %0d",
						key_pressed, position, calibration);
					fails++;
				end else begin
					want = result_q.pop_front();
					if (key_pressed !== want.pressed) begin
						$error("key_pressed: expected %0d, got %0d", want.pressed, key_pressed);
						fails++;
					end
					if (position !== want.position) begin
						$error("position: expected %0d, got %0d", want.position, position);
						fails++;
					end
					if (calibration !== want.calibration) begin
						$error("calibration: expected %0d, got %0d", want.calibration,
							calibration);
						fails++;
					end
					n_results++;
				end
			end
			if (in_taken || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("analog_key_rapid_trigger: mismatch");
				$finish;
			end
		end
	end

	initial begin
		int p;
		int mode;
		int mode_base;
		int start;
		int rest;
		int rng;
		int press;
		int rel;
		int tdz;
		int bdz;
		int count;
		bit up;
		bit drained;
		reset_key_model();
		send_idle = 16;
		recv_idle = 74;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: no lock at the edge of the range, then lock positive
		sample_q = '{2048, 2348, 1748, 4095, 3000, 2200, 0, DRAIN_MARK};
		settle();
		// digital with the unused start code, unlocked nonzero sample releases
		load_setting(MODE_DIGITAL, CAL_RESERVED, 2048, 300, 200, 150, 20, 20);
		sample_q = '{2100, 0, 1024};
		settle();
		// zero span until a sample widens the far bound
		load_setting(MODE_RAPID, CAL_POS, 1000, 0, 200, 150, 20, 20);
		sample_q = '{1000, 900, 1500, 1300, 1400, 1100};
		settle();
		load_setting(MODE_SPEED, CAL_NEG, 3000, 1000, 100, -100, 20, 20);
		sample_q = '{3000, 2000, 2500, 1900, 3100};
		settle();

		mode_base = $urandom_range(3);
		for (p = 0; p < 8; p++) begin
			if (p < 3) begin
				send_idle = 16;
				recv_idle = 74;
			end else if (p < 6) begin
				send_idle = 74;
				recv_idle = 16;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			mode = (p + mode_base) % 4;
			start = $urandom_range(3);
			rest = $urandom_range(600, 3500);
			rng = $urandom_range(30, 900);
			tdz = $urandom_range(40);
			bdz = $urandom_range(40);
			case (mode)
			MODE_THRESH: begin
				press = $urandom_range(10, 600);
				rel = $urandom_range(press);
			end
			MODE_RAPID: begin
				press = $urandom_range(5, 200);
				rel = $urandom_range(5, 200);
			end
			default: begin
				press = $urandom_range(5, 150);
				rel = -int'($urandom_range(5, 150));
			end
			endcase
			case (p)
			1: begin
				rest = 4095;
				rng = 4095;
				start = CAL_NEG;
			end
			2: begin
				rest = 0;
				start = CAL_POS;
				tdz = 0;
				bdz = 0;
			end
			3: begin
				press = 1023;
				rel = -1023;
			end
			4: begin
				press = -1023;
				rel = 1023;
			end
			5: begin
				tdz = 1023;
				bdz = 1023;
			end
			6: begin
				rng = 0;
				start = CAL_POS;
			end
			7: rng = 1;
			default: ;
			endcase
			load_setting(mode, start, rest, rng, press, rel, tdz, bdz);
			up = (start == CAL_POS) || (start != CAL_NEG && $urandom_range(1) == 1);
			count = 0;
			drained = 1'b0;
			while (count < 44) begin
				if ($urandom_range(9) < 8) begin
					count += push_stroke(rest, rng, up);
				end else begin
					sample_q.push_back($urandom_range(4095));
					count++;
				end
				if (!drained && count >= 25) begin
					sample_q.push_back(DRAIN_MARK);
					drained = 1'b1;
				end
			end
			settle();
		end

		$display("run: %0d samples in, %0d results checked, %0d register writes over %0d settings",
			n_samples, n_results, n_writes, n_settings);
		$display("run: all four modes, locked and unlocked calibration, zero and full spans");
		if (fails == 0)
			$display("analog_key_rapid_trigger: match");
		else
			$display("analog_key_rapid_trigger: mismatch");
		$finish;
	end

endmodule
